/* hdl/chgs_pkg.sv */
package chgs_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 31;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;

  // Source of the point memory read address
  typedef enum logic [1:0] {
    PT_CTRL,
    PT_ORD,
    PT_STK
  } pt_src_t;

  // Which coordinate register takes the point memory read data
  typedef enum logic [1:0] {
    CAP_NONE,
    CAP_BASE,
    CAP_Q,
    CAP_R
  } cap_t;

  // Source of an index written to the order or stack memory
  typedef enum logic [1:0] {
    SRC_BASE,
    SRC_Q,
    SRC_R,
    SRC_ORD
  } idx_src_t;

  // Multiplier operation
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_L,
    MUL_R,
    MUL_AX,
    MUL_AY,
    MUL_BX,
    MUL_BY
  } mul_t;

  // Output register load
  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_HULL,
    OUT_ERR
  } out_ld_t;

  typedef struct packed {
    logic             pt_we;
    logic [IDX_W-1:0] pt_waddr;
    pt_src_t          pt_rsrc;
    logic [IDX_W-1:0] pt_raddr;
    cap_t             cap;
    logic             ord_we;
    logic [IDX_W-1:0] ord_waddr;
    idx_src_t         ord_wsrc;
    logic [IDX_W-1:0] ord_raddr;
    logic             stk_we;
    logic [IDX_W-1:0] stk_waddr;
    idx_src_t         stk_wsrc;
    logic [IDX_W-1:0] stk_raddr;
    logic             diff_en;
    mul_t             mul;
    out_ld_t          out_ld;
    logic             out_last;
  } cmd_t;

  typedef struct packed {
    logic better_pivot;
    logic turn_cw;
    logic turn_ccw;
    logic dist_lt;
    logic dist_eq;
    logic idx_lt;
  } status_t;

endpackage

/* hdl/chgs_dp.sv */
module chgs_dp (
  input  logic                                    clk,
  input  logic signed [chgs_pkg::COORD_BITS-1:0]  point_x,
  input  logic signed [chgs_pkg::COORD_BITS-1:0]  point_y,
  input  chgs_pkg::cmd_t                          cmd,
  output chgs_pkg::status_t                       status,
  output logic signed [chgs_pkg::COORD_BITS-1:0]  hull_x,
  output logic signed [chgs_pkg::COORD_BITS-1:0]  hull_y,
  output logic [chgs_pkg::CNT_W-1:0]              hull_id,
  output logic                                    hull_last,
  output logic                                    too_few
);

  localparam int CB = chgs_pkg::COORD_BITS;
  localparam int IW = chgs_pkg::IDX_W;
  localparam int DW = chgs_pkg::DIFF_W;
  localparam int PW = chgs_pkg::PROD_W;

  logic [2*CB-1:0] pt_mem [chgs_pkg::MAX_POINTS];
  logic [IW-1:0]   ord_mem [chgs_pkg::MAX_POINTS];
  logic [IW-1:0]   stk_mem [chgs_pkg::MAX_POINTS];

  logic [2*CB-1:0] pt_rdata;
  logic [IW-1:0]   pt_addr_q;
  logic [IW-1:0]   pt_raddr;
  logic [IW-1:0]   ord_rdata;
  logic [IW-1:0]   stk_rdata;

  logic signed [CB-1:0] rd_x, rd_y;
  logic signed [CB-1:0] base_x, base_y, q_x, q_y, r_x, r_y;
  logic [IW-1:0]        base_idx, q_idx, r_idx;

  logic signed [DW-1:0] d1x, d1y, d2x, d2y;
  logic signed [DW-1:0] ma, mb;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] l_prod, r_prod;
  logic [PW-1:0]        dist_a, dist_b;

  logic [IW-1:0] ord_wdata, stk_wdata;

  assign rd_x = pt_rdata[2*CB-1:CB];
  assign rd_y = pt_rdata[CB-1:0];

  // Pick the point read address
  always_comb begin
    unique case (cmd.pt_rsrc)
      chgs_pkg::PT_ORD: pt_raddr = ord_rdata;
      chgs_pkg::PT_STK: pt_raddr = stk_rdata;
      default:          pt_raddr = cmd.pt_raddr;
    endcase
  end

  // Pick the index written to the order and stack memories
  always_comb begin
    unique case (cmd.ord_wsrc)
      chgs_pkg::SRC_BASE: ord_wdata = base_idx;
      chgs_pkg::SRC_Q:    ord_wdata = q_idx;
      chgs_pkg::SRC_R:    ord_wdata = r_idx;
      default:            ord_wdata = ord_rdata;
    endcase
    unique case (cmd.stk_wsrc)
      chgs_pkg::SRC_BASE: stk_wdata = base_idx;
      chgs_pkg::SRC_Q:    stk_wdata = q_idx;
      chgs_pkg::SRC_R:    stk_wdata = r_idx;
      default:            stk_wdata = ord_rdata;
    endcase
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (cmd.pt_we) begin
      pt_mem[cmd.pt_waddr] <= {point_x, point_y};
    end
    pt_rdata  <= pt_mem[pt_raddr];
    pt_addr_q <= pt_raddr;
    if (cmd.ord_we) begin
      ord_mem[cmd.ord_waddr] <= ord_wdata;
    end
    ord_rdata <= ord_mem[cmd.ord_raddr];
    if (cmd.stk_we) begin
      stk_mem[cmd.stk_waddr] <= stk_wdata;
    end
    stk_rdata <= stk_mem[cmd.stk_raddr];
  end

  // Capture fetched points
  always_ff @(posedge clk) begin
    unique case (cmd.cap)
      chgs_pkg::CAP_BASE: begin
        base_x   <= rd_x;
        base_y   <= rd_y;
        base_idx <= pt_addr_q;
      end
      chgs_pkg::CAP_Q: begin
        q_x   <= rd_x;
        q_y   <= rd_y;
        q_idx <= pt_addr_q;
      end
      chgs_pkg::CAP_R: begin
        r_x   <= rd_x;
        r_y   <= rd_y;
        r_idx <= pt_addr_q;
      end
      default: ;
    endcase
  end

  // Form the two vectors from the base point
  always_ff @(posedge clk) begin
    if (cmd.diff_en) begin
      d1x <= DW'(q_x) - DW'(base_x);
      d1y <= DW'(q_y) - DW'(base_y);
      d2x <= DW'(r_x) - DW'(base_x);
      d2y <= DW'(r_y) - DW'(base_y);
    end
  end

  // Shared multiplier operand select
  always_comb begin
    unique case (cmd.mul)
      chgs_pkg::MUL_L:  begin ma = d1y; mb = d2x; end
      chgs_pkg::MUL_R:  begin ma = d2y; mb = d1x; end
      chgs_pkg::MUL_AX: begin ma = d1x; mb = d1x; end
      chgs_pkg::MUL_AY: begin ma = d1y; mb = d1y; end
      chgs_pkg::MUL_BX: begin ma = d2x; mb = d2x; end
      chgs_pkg::MUL_BY: begin ma = d2y; mb = d2y; end
      default:          begin ma = d1x; mb = d2x; end
    endcase
  end

  assign prod = PW'(ma) * PW'(mb);

  // Hold cross terms and squared distances
  always_ff @(posedge clk) begin
    unique case (cmd.mul)
      chgs_pkg::MUL_L:  l_prod <= prod;
      chgs_pkg::MUL_R:  r_prod <= prod;
      chgs_pkg::MUL_AX: dist_a <= $unsigned(prod);
      chgs_pkg::MUL_AY: dist_a <= dist_a + $unsigned(prod);
      chgs_pkg::MUL_BX: dist_b <= $unsigned(prod);
      chgs_pkg::MUL_BY: dist_b <= dist_b + $unsigned(prod);
      default: ;
    endcase
  end

  assign status.better_pivot = (rd_x < base_x) || ((rd_x == base_x) && (rd_y < base_y));
  assign status.turn_cw      = l_prod > r_prod;
  assign status.turn_ccw     = l_prod < r_prod;
  assign status.dist_lt      = dist_a < dist_b;
  assign status.dist_eq      = dist_a == dist_b;
  assign status.idx_lt       = q_idx < r_idx;

  // Output register
  always_ff @(posedge clk) begin
    unique case (cmd.out_ld)
      chgs_pkg::OUT_HULL: begin
        hull_x    <= rd_x;
        hull_y    <= rd_y;
        hull_id   <= chgs_pkg::CNT_W'(pt_addr_q) + chgs_pkg::CNT_W'(1);
        hull_last <= cmd.out_last;
        too_few   <= 1'b0;
      end
      chgs_pkg::OUT_ERR: begin
        hull_x    <= '0;
        hull_y    <= '0;
        hull_id   <= '0;
        hull_last <= 1'b1;
        too_few   <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

/* hdl/chgs_ctrl.sv */
module chgs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              final_point,
  output logic              out_valid,
  input  logic              out_ready,
  input  chgs_pkg::status_t status,
  output chgs_pkg::cmd_t    cmd
);

  localparam int IW = chgs_pkg::IDX_W;
  localparam int CW = chgs_pkg::CNT_W;

  typedef enum logic [4:0] {
    LOAD, PIV_RD, PIV_CMP,
    SORT_I, SORT_QLD, SORT_J, SORT_JRD, SORT_RRD, SORT_PUT,
    CMP_DIFF, CMP_L, CMP_R, CMP_EVAL,
    DST_AX, DST_AY, DST_BX, DST_BY, DST_EVAL,
    SCAN_INIT, SCAN_S1, SCAN_S2, SCAN_I, SCAN_PUSH, SCAN_CHK,
    SCAN_F1, SCAN_F2, SCAN_F3, SCAN_F4,
    OUT_RD, OUT_R2, OUT_R3, OUT_W
  } state_t;

  state_t        state;
  logic [CW-1:0] cnt, n, i, j, m, d, k;
  logic [IW-1:0] pv;
  logic          scan_mode;
  logic          last_r;

  logic          has_room;
  logic [CW-1:0] cnt_next;
  logic [CW-1:0] i_inc, j_dec, d_m1, d_m2, d_m3, k_inc;
  logic          collinear;
  logic          sort_before;

  assign has_room    = cnt < CW'(chgs_pkg::MAX_POINTS);
  assign cnt_next    = has_room ? cnt + CW'(1) : cnt;
  assign i_inc       = i + CW'(1);
  assign j_dec       = j - CW'(1);
  assign d_m1        = d - CW'(1);
  assign d_m2        = d - CW'(2);
  assign d_m3        = d - CW'(3);
  assign k_inc       = k + CW'(1);
  assign collinear   = !status.turn_cw && !status.turn_ccw;
  assign sort_before = status.dist_lt || (status.dist_eq && status.idx_lt);
  assign in_ready    = state == LOAD;

  // Issue datapath commands per state
  always_comb begin
    cmd = '0;
    unique case (state)
      LOAD: begin
        cmd.pt_we    = in_valid && has_room;
        cmd.pt_waddr = cnt[IW-1:0];
        // load the error result when a short set ends
        if (in_valid && final_point && (cnt_next < CW'(3))) begin
          cmd.out_ld = chgs_pkg::OUT_ERR;
        end
      end
      PIV_RD:   cmd.pt_raddr = i[IW-1:0];
      PIV_CMP:  cmd.cap = ((i == '0) || status.better_pivot) ? chgs_pkg::CAP_BASE
                                                              : chgs_pkg::CAP_NONE;
      SORT_I:   cmd.pt_raddr = i[IW-1:0];
      SORT_QLD: cmd.cap = chgs_pkg::CAP_Q;
      SORT_J:   cmd.ord_raddr = j_dec[IW-1:0];
      SORT_JRD: cmd.pt_rsrc = chgs_pkg::PT_ORD;
      SORT_RRD: cmd.cap = chgs_pkg::CAP_R;
      SORT_PUT: begin
        cmd.ord_we    = 1'b1;
        cmd.ord_waddr = j[IW-1:0];
        cmd.ord_wsrc  = chgs_pkg::SRC_Q;
      end
      CMP_DIFF: cmd.diff_en = 1'b1;
      CMP_L:    cmd.mul = chgs_pkg::MUL_L;
      CMP_R:    cmd.mul = chgs_pkg::MUL_R;
      CMP_EVAL: begin
        if (scan_mode) begin
          // drop the middle point of a counterclockwise turn
          cmd.stk_we    = status.turn_ccw;
          cmd.stk_waddr = d_m2[IW-1:0];
          cmd.stk_wsrc  = chgs_pkg::SRC_R;
        end else begin
          cmd.ord_we    = status.turn_cw;
          cmd.ord_waddr = j[IW-1:0];
          cmd.ord_wsrc  = chgs_pkg::SRC_R;
        end
      end
      DST_AX:   cmd.mul = chgs_pkg::MUL_AX;
      DST_AY:   cmd.mul = chgs_pkg::MUL_AY;
      DST_BX:   cmd.mul = chgs_pkg::MUL_BX;
      DST_BY:   cmd.mul = chgs_pkg::MUL_BY;
      DST_EVAL: begin
        cmd.ord_we    = sort_before;
        cmd.ord_waddr = j[IW-1:0];
        cmd.ord_wsrc  = chgs_pkg::SRC_R;
      end
      SCAN_INIT: begin
        cmd.stk_we    = 1'b1;
        cmd.stk_waddr = IW'(0);
        cmd.stk_wsrc  = chgs_pkg::SRC_BASE;
        cmd.ord_raddr = IW'(0);
      end
      SCAN_S1: begin
        cmd.stk_we    = 1'b1;
        cmd.stk_waddr = IW'(1);
        cmd.stk_wsrc  = chgs_pkg::SRC_ORD;
        cmd.ord_raddr = IW'(1);
      end
      SCAN_S2: begin
        cmd.stk_we    = 1'b1;
        cmd.stk_waddr = IW'(2);
        cmd.stk_wsrc  = chgs_pkg::SRC_ORD;
      end
      SCAN_I:   cmd.ord_raddr = i[IW-1:0];
      SCAN_PUSH: begin
        cmd.stk_we    = 1'b1;
        cmd.stk_waddr = d[IW-1:0];
        cmd.stk_wsrc  = chgs_pkg::SRC_ORD;
      end
      SCAN_CHK: cmd.stk_raddr = d_m3[IW-1:0];
      SCAN_F1: begin
        cmd.pt_rsrc   = chgs_pkg::PT_STK;
        cmd.stk_raddr = d_m2[IW-1:0];
      end
      SCAN_F2: begin
        cmd.cap       = chgs_pkg::CAP_BASE;
        cmd.pt_rsrc   = chgs_pkg::PT_STK;
        cmd.stk_raddr = d_m1[IW-1:0];
      end
      SCAN_F3: begin
        cmd.cap     = chgs_pkg::CAP_Q;
        cmd.pt_rsrc = chgs_pkg::PT_STK;
      end
      SCAN_F4:  cmd.cap = chgs_pkg::CAP_R;
      OUT_RD:   cmd.stk_raddr = k[IW-1:0];
      OUT_R2:   cmd.pt_rsrc = chgs_pkg::PT_STK;
      OUT_R3: begin
        cmd.out_ld   = chgs_pkg::OUT_HULL;
        cmd.out_last = k_inc == d;
      end
      OUT_W: ;
      default: ;
    endcase
  end

  // Hold state, loop counters and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= LOAD;
      cnt       <= '0;
      out_valid <= 1'b0;
      scan_mode <= 1'b0;
    end else begin
      unique case (state)
        LOAD: begin
          if (in_valid) begin
            cnt <= cnt_next;
            if (final_point) begin
              cnt       <= '0;
              n         <= cnt_next;
              i         <= '0;
              scan_mode <= 1'b0;
              state     <= PIV_RD;
              if (cnt_next < CW'(3)) begin
                state <= OUT_W;
                out_valid <= 1'b1;
                last_r    <= 1'b1;
              end
            end
          end
        end
        PIV_RD:  state <= PIV_CMP;
        PIV_CMP: begin
          if ((i == '0) || status.better_pivot) begin
            pv <= i[IW-1:0];
          end
          if (i_inc == n) begin
            i     <= '0;
            m     <= '0;
            state <= SORT_I;
          end else begin
            i     <= i_inc;
            state <= PIV_RD;
          end
        end
        SORT_I: begin
          if (i == n) begin
            scan_mode <= 1'b1;
            state     <= SCAN_INIT;
          end else if (i[IW-1:0] == pv) begin
            i <= i_inc;
          end else begin
            j     <= m;
            state <= SORT_QLD;
          end
        end
        SORT_QLD: state <= SORT_J;
        SORT_J:   state <= (j == '0) ? SORT_PUT : SORT_JRD;
        SORT_JRD: state <= SORT_RRD;
        SORT_RRD: state <= CMP_DIFF;
        SORT_PUT: begin
          m     <= m + CW'(1);
          i     <= i_inc;
          state <= SORT_I;
        end
        CMP_DIFF: state <= CMP_L;
        CMP_L:    state <= CMP_R;
        CMP_R:    state <= CMP_EVAL;
        CMP_EVAL: begin
          if (scan_mode) begin
            if (status.turn_ccw) begin
              d     <= d_m1;
              state <= SCAN_CHK;
            end else begin
              state <= SCAN_I;
            end
          end else if (collinear) begin
            state <= DST_AX;
          end else if (status.turn_cw) begin
            j     <= j_dec;
            state <= SORT_J;
          end else begin
            state <= SORT_PUT;
          end
        end
        DST_AX: state <= DST_AY;
        DST_AY: state <= DST_BX;
        DST_BX: state <= DST_BY;
        DST_BY: state <= DST_EVAL;
        DST_EVAL: begin
          if (sort_before) begin
            j     <= j_dec;
            state <= SORT_J;
          end else begin
            state <= SORT_PUT;
          end
        end
        SCAN_INIT: state <= SCAN_S1;
        SCAN_S1:   state <= SCAN_S2;
        SCAN_S2: begin
          d     <= CW'(3);
          i     <= CW'(2);
          state <= SCAN_I;
        end
        SCAN_I: begin
          if (i == m) begin
            k     <= '0;
            state <= OUT_RD;
          end else begin
            state <= SCAN_PUSH;
          end
        end
        SCAN_PUSH: begin
          d     <= d + CW'(1);
          i     <= i_inc;
          state <= SCAN_CHK;
        end
        SCAN_CHK: state <= (d > CW'(3)) ? SCAN_F1 : SCAN_I;
        SCAN_F1:  state <= SCAN_F2;
        SCAN_F2:  state <= SCAN_F3;
        SCAN_F3:  state <= SCAN_F4;
        SCAN_F4:  state <= CMP_DIFF;
        OUT_RD:   state <= OUT_R2;
        OUT_R2:   state <= OUT_R3;
        OUT_R3: begin
          out_valid <= 1'b1;
          last_r    <= k_inc == d;
          state     <= OUT_W;
        end
        OUT_W: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_r) begin
              state <= LOAD;
            end else begin
              k     <= k_inc;
              state <= OUT_RD;
            end
          end
        end
        default: state <= LOAD;
      endcase
    end
  end

endmodule

/* hdl/convex_hull_graham_scan.sv */
// Load: a point is taken in every cycle while loading.
// Hull: a pivot search, an insertion sort (n*n/2 comparisons at worst) and
// the turn tests of a stack scan, paced by the single shared multiplier and
// the one-read-port memories. Output: each hull vertex is read through the
// stack and point memories and held until taken; the error result reads none.
// Reset (rst, synchronous) empties the point set and drops any pending result.
module convex_hull_graham_scan (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [chgs_pkg::COORD_BITS-1:0]  point_x,
  input  logic signed [chgs_pkg::COORD_BITS-1:0]  point_y,
  input  logic                                    final_point,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [chgs_pkg::COORD_BITS-1:0]  hull_x,
  output logic signed [chgs_pkg::COORD_BITS-1:0]  hull_y,
  output logic [chgs_pkg::CNT_W-1:0]              hull_id,
  output logic                                    hull_last,
  output logic                                    too_few
);

  chgs_pkg::cmd_t    cmd;
  chgs_pkg::status_t status;

  chgs_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .final_point (final_point),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .cmd         (cmd)
  );

  chgs_dp u_dp (
    .clk       (clk),
    .point_x   (point_x),
    .point_y   (point_y),
    .cmd       (cmd),
    .status    (status),
    .hull_x    (hull_x),
    .hull_y    (hull_y),
    .hull_id   (hull_id),
    .hull_last (hull_last),
    .too_few   (too_few)
  );

endmodule

/* hdl/chgs_checker.sv */
module chgs_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    in_valid,
  input logic                                    in_ready,
  input logic                                    out_valid,
  input logic                                    out_ready,
  input logic signed [chgs_pkg::COORD_BITS-1:0]  hull_x,
  input logic [chgs_pkg::CNT_W-1:0]              hull_id,
  input logic                                    hull_last,
  input logic                                    too_few
);

  // Loading and result delivery never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // Error result is the only and last result
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && too_few) |-> (hull_last && (hull_id == '0)))
    else $error("error result malformed");

  // A hull vertex carries a nonzero arrival number
  a_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !too_few) |-> (hull_id != '0))
    else $error("hull vertex with zero id");

  // Last vertex transfer returns the block to loading
  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && hull_last) |=> in_ready)
    else $error("block did not return to loading");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(hull_x) && $stable(hull_id)))
    else $error("stalled result changed");

endmodule

bind convex_hull_graham_scan chgs_checker u_chgs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .hull_x    (hull_x),
  .hull_id   (hull_id),
  .hull_last (hull_last),
  .too_few   (too_few)
);

/* test/convex_hull_graham_scan_test.sv */
module convex_hull_graham_scan_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [chgs_pkg::COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t                     x;
    coord_t                     y;
    logic [chgs_pkg::CNT_W-1:0] id;
    logic                       last;
    logic                       few;
  } vertex_t;

  // Hull predictor: keeps its own copy of the point set and the expected vertices
  class hull_scoreboard;
    longint  px[chgs_pkg::MAX_POINTS];
    longint  py[chgs_pkg::MAX_POINTS];
    int      npts;
    int      errors;
    vertex_t hull_q[$];

    function int turn_dir(int a, int b, int c);
      longint l;
      longint r;
      l = (py[b] - py[a]) * (px[c] - px[a]);
      r = (py[c] - py[a]) * (px[b] - px[a]);
      if (l < r) return -1;
      if (l == r) return 0;
      return 1;
    endfunction

    function longint unsigned span2(int a, int b);
      longint unsigned ux;
      longint unsigned uy;
      ux = (px[a] > px[b]) ? px[a] - px[b] : px[b] - px[a];
      uy = (py[a] > py[b]) ? py[a] - py[b] : py[b] - py[a];
      return ux * ux + uy * uy;
    endfunction

    function bit sorts_first(int pv, int a, int b);
      int t;
      longint unsigned da;
      longint unsigned db;
      t = turn_dir(pv, a, b);
      if (t != 0) return t > 0;
      da = span2(pv, a);
      db = span2(pv, b);
      if (da != db) return da < db;
      return a < b;
    endfunction

    // Note an accepted point; on the final one, predict the hull
    function void note_point(coord_t x, coord_t y, logic fin);
      int n;
      int pv;
      int m;
      int j;
      int sp;
      int ord[chgs_pkg::MAX_POINTS];
      int stk[chgs_pkg::MAX_POINTS];
      vertex_t v;
      if (npts < chgs_pkg::MAX_POINTS) begin
        px[npts] = longint'(x);
        py[npts] = longint'(y);
        npts++;
      end
      if (!fin) return;
      n = npts;
      npts = 0;
      if (n < 3) begin
        v.x = '0; v.y = '0; v.id = '0; v.last = 1'b1; v.few = 1'b1;
        hull_q = {hull_q, v};
        return;
      end
      // pick the leftmost, then lowest, then earliest point
      pv = 0;
      for (int i = 1; i < n; i++) begin
        if ((px[pv] == px[i] && py[pv] > py[i]) || px[pv] > px[i]) pv = i;
      end
      // insertion sort clockwise around the pivot
      m = 0;
      for (int i = 0; i < n; i++) begin
        if (i == pv) continue;
        j = m;
        while (j > 0 && sorts_first(pv, i, ord[j-1])) begin
          ord[j] = ord[j-1];
          j--;
        end
        ord[j] = i;
        m++;
      end
      // stack scan: drop the middle point of counterclockwise turns
      stk[0] = pv;
      stk[1] = ord[0];
      stk[2] = ord[1];
      sp = 3;
      for (int i = 2; i < m; i++) begin
        stk[sp] = ord[i];
        sp++;
        while (sp > 3 && turn_dir(stk[sp-3], stk[sp-2], stk[sp-1]) < 0) begin
          stk[sp-2] = stk[sp-1];
          sp--;
        end
      end
      for (int k = 0; k < sp; k++) begin
        v.x = coord_t'(px[stk[k]]);
        v.y = coord_t'(py[stk[k]]);
        v.id = chgs_pkg::CNT_W'(stk[k] + 1);
        v.last = (k == sp - 1);
        v.few = 1'b0;
        hull_q = {hull_q, v};
      end
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t e;
      if (hull_q.size() == 0) begin
        $error("unexpected hull vertex x=%0d y=%0d id=%0d", got.x, got.y, got.id);
        errors++;
        return;
      end
      e = hull_q.pop_front();
      if (got.x !== e.x) begin
        $error("hull_x expected %0d actual %0d", e.x, got.x); errors++;
      end
      if (got.y !== e.y) begin
        $error("hull_y expected %0d actual %0d", e.y, got.y); errors++;
      end
      if (got.id !== e.id) begin
        $error("hull_id expected %0d actual %0d", e.id, got.id); errors++;
      end
      if (got.last !== e.last) begin
        $error("hull_last expected %0b actual %0b", e.last, got.last); errors++;
      end
      if (got.few !== e.few) begin
        $error("too_few expected %0b actual %0b", e.few, got.few); errors++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 300000;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  coord_t                     point_x = '0;
  coord_t                     point_y = '0;
  logic                       final_point = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  coord_t                     hull_x;
  coord_t                     hull_y;
  logic [chgs_pkg::CNT_W-1:0] hull_id;
  logic                       hull_last;
  logic                       too_few;

  hull_scoreboard hull_sb = new();
  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold;
  int points_sent;
  int quiet_cycles = 0;

  convex_hull_graham_scan dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one point and hold it until the transfer
  task automatic send_point(coord_t x, coord_t y, logic fin);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    point_x <= x;
    point_y <= y;
    final_point <= fin;
    do @(posedge clk); while (!in_ready);
    hull_sb.note_point(x, y, fin);
    points_sent++;
  endtask

  function automatic coord_t rand_coord(int mode);
    if (mode == 0) return coord_t'($urandom);
    if (mode == 1) return coord_t'($urandom_range(0, 8) - 4);
    case ($urandom_range(0, 3))
      0: return {1'b1, {(chgs_pkg::COORD_BITS-1){1'b0}}};
      1: return {1'b0, {(chgs_pkg::COORD_BITS-1){1'b1}}};
      2: return '0;
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic send_set(int n, int mode);
    for (int i = 0; i < n; i++) send_point(rand_coord(mode), rand_coord(mode), i == n - 1);
  endtask

  // Pause the sender until every expected vertex has come
  task automatic drain();
    in_valid <= 1'b0;
    while (hull_sb.hull_q.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls plus an optional long hold-off
  always begin
    out_ready <= !(recv_hold > 0 || $urandom_range(0, 99) < recv_idle_pct);
    @(posedge clk);
    if (recv_hold > 0) recv_hold--;
    if (!rst && out_valid && out_ready)
      hull_sb.check_vertex('{hull_x, hull_y, hull_id, hull_last, too_few});
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    coord_t lo;
    coord_t hi;
    lo = {1'b1, {(chgs_pkg::COORD_BITS-1){1'b0}}};
    hi = {1'b0, {(chgs_pkg::COORD_BITS-1){1'b1}}};
    send_idle_pct = 34;
    recv_idle_pct = 60;
    recv_hold = 0;
    points_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // too few: one point, then two points
    send_point(hi, hi, 1'b1);
    send_point(lo, 5, 1'b0);
    send_point(lo, 5, 1'b1);
    // three collinear points
    send_point(0, 0, 1'b0);
    send_point(2, 2, 1'b0);
    send_point(1, 1, 1'b1);
    // extreme square with pivot copy, edge midpoint, interior and duplicates
    send_point(hi, hi, 1'b0);
    send_point(lo, lo, 1'b0);
    send_point(hi, lo, 1'b0);
    send_point(lo, hi, 1'b0);
    send_point(lo, lo, 1'b0);
    send_point(lo, 0, 1'b0);
    send_point(0, 0, 1'b0);
    send_point(0, 0, 1'b0);
    send_point(hi, 0, 1'b1);
    // concave shape with a counterclockwise dent
    send_point(0, 0, 1'b0);
    send_point(4, 0, 1'b0);
    send_point(2, 1, 1'b0);
    send_point(4, 4, 1'b0);
    send_point(0, 4, 1'b1);
    drain();

    // long receiver hold-off while the sender keeps offering
    recv_hold = 4000;
    send_set(20, 1);
    send_set(6, 0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 60 : 0;
      recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 34 : 0;
      if (phase == 1) send_set(70, 1);
      while (points_sent < 46 + (phase + 1) * 72) begin
        case ($urandom_range(0, 9))
          0:       send_set($urandom_range(1, 2), 0);
          1, 2, 3: send_set($urandom_range(3, 12), 1);
          4:       send_set($urandom_range(3, 8), 2);
          default: send_set($urandom_range(3, 12), 0);
        endcase
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (hull_sb.errors == 0 && hull_sb.hull_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

/* files.f */
hdl/chgs_pkg.sv
hdl/chgs_dp.sv
hdl/chgs_ctrl.sv
hdl/convex_hull_graham_scan.sv
hdl/chgs_checker.sv
test/convex_hull_graham_scan_test.sv
